/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Both take a label, a clock, a reset
// (active low), the property and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TBNE_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (prop)) else $error(msg);
`define TBNE_NEVER(lbl, clk_i, rstn_i, cond, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) !(cond)) else $error(msg);
`else
`define TBNE_ASSERT(lbl, clk_i, rstn_i, prop, msg)
`define TBNE_NEVER(lbl, clk_i, rstn_i, cond, msg)
`endif
`endif

/* rtl/tbne_pkg.sv */
`default_nettype none
package tbne_pkg;

	localparam int SLOT_W = 4;
	localparam logic [29:0] NS_MAX = 30'd999999999;
	localparam logic [30:0] NS_PER_SEC = 31'd1000000000;

	localparam logic [2:0] MODE_ARM    = 3'd0;
	localparam logic [2:0] MODE_REARM  = 3'd1;
	localparam logic [2:0] MODE_CANCEL = 3'd2;
	localparam logic [2:0] MODE_QUERY  = 3'd3;
	localparam logic [2:0] MODE_POLL   = 3'd4;

	typedef struct packed {
		logic [2:0]        mode;
		logic [31:0]       now_sec;
		logic [29:0]       now_nsec;
		logic [31:0]       interval_sec;
		logic [29:0]       interval_nsec;
		logic [SLOT_W-1:0] slot_index;
	} cmd_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] result_slot;
		logic [31:0]       remain_sec;
		logic [29:0]       remain_nsec;
	} rsp_t;

	// Command travelling down the chain together with the running result.
	typedef struct packed {
		logic [2:0]        mode;
		logic [31:0]       now_sec;
		logic [29:0]       now_nsec;
		logic [31:0]       ivl_sec;
		logic [29:0]       ivl_nsec;
		logic [SLOT_W-1:0] slot;
		logic              found;
		logic [SLOT_W-1:0] rslot;
		logic [32:0]       best_sec;
		logic [29:0]       best_nsec;
	} pkt_t;

endpackage
`default_nettype wire

/* rtl/timer_bank_next_expiry.sv */
`default_nettype none
`include "assert_macros.svh"
// Pool of NUM_TIMERS one-shot timers. Each command beat walks down a row of
// timer cells, one cell per cycle, and from the last cell into a registered
// response beat. One command is in flight at a time: cmd_stall is high from
// acceptance until the response beat is taken.
module timer_bank_next_expiry import tbne_pkg::*; #(
	parameter int NUM_TIMERS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_stall,
	input  wire cmd_t cmd,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	logic busy_q;
	logic rsp_valid_q;
	rsp_t rsp_q;
	logic cmd_acc, rsp_acc;

	logic vld [NUM_TIMERS+1];
	pkt_t pkt [NUM_TIMERS+1];

	pkt_t        last;
	logic        later;
	logic [32:0] dsec;
	logic [29:0] dnsec;
	rsp_t        rsp_d;

	assign cmd_stall = busy_q;
	assign cmd_acc   = cmd_valid && !busy_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_acc   = rsp_valid_q && !rsp_stall;

	always_comb begin
		pkt[0]           = '0;
		pkt[0].mode      = cmd.mode;
		pkt[0].now_sec   = cmd.now_sec;
		pkt[0].now_nsec  = (cmd.now_nsec > NS_MAX) ? NS_MAX : cmd.now_nsec;
		pkt[0].ivl_sec   = cmd.interval_sec;
		pkt[0].ivl_nsec  = (cmd.interval_nsec > NS_MAX) ? NS_MAX : cmd.interval_nsec;
		pkt[0].slot      = cmd.slot_index;
	end
	assign vld[0] = cmd_acc;

	for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
		tbne_cell #(.IDX(g)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_in (vld[g]),
			.pkt_in (pkt[g]),
			.vld_q  (vld[g+1]),
			.pkt_q  (pkt[g+1])
		);
	end

	// Time left on the earliest deadline, borrowing a second when needed.
	assign last  = pkt[NUM_TIMERS];
	assign later = {last.best_sec, last.best_nsec} > {1'b0, last.now_sec, last.now_nsec};

	always_comb begin
		if (last.best_nsec < last.now_nsec) begin
			dnsec = 30'(({1'b0, last.best_nsec} + NS_PER_SEC) - {1'b0, last.now_nsec});
			dsec  = last.best_sec - {1'b0, last.now_sec} - 33'd1;
		end else begin
			dnsec = last.best_nsec - last.now_nsec;
			dsec  = last.best_sec - {1'b0, last.now_sec};
		end
	end

	always_comb begin
		rsp_d             = '0;
		rsp_d.found       = last.found;
		rsp_d.result_slot = last.found ? last.rslot : '0;
		if (last.mode == MODE_QUERY && last.found && later) begin
			if (dsec[32]) begin
				rsp_d.remain_sec  = '1;
				rsp_d.remain_nsec = NS_MAX;
			end else begin
				rsp_d.remain_sec  = dsec[31:0];
				rsp_d.remain_nsec = dnsec;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd_acc) begin
				busy_q <= 1'b1;
			end else if (rsp_acc) begin
				busy_q <= 1'b0;
			end
			if (vld[NUM_TIMERS]) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_acc) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld[NUM_TIMERS]) begin
			rsp_q <= rsp_d;
		end
	end

	`TBNE_ASSERT(a_rsp_busy, clk, arst_n, rsp_valid_q |-> busy_q, "response without command")
	`TBNE_ASSERT(a_acc_busy, clk, arst_n, cmd_acc |=> busy_q, "busy not set on command")
	`TBNE_NEVER(a_idle_chain, clk, arst_n, vld[NUM_TIMERS] && !busy_q, "chain beat while idle")
	`TBNE_NEVER(a_slot_zero, clk, arst_n, rsp_valid_q && !rsp_q.found && rsp_q.result_slot != '0, "slot without found")
	`TBNE_NEVER(a_ns_range, clk, arst_n, rsp_valid_q && rsp_q.remain_nsec > NS_MAX, "nanoseconds out of range")

endmodule
`default_nettype wire

/* rtl/tbne_cell.sv */
`default_nettype none
module tbne_cell import tbne_pkg::*; #(
	parameter int IDX = 0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic vld_in,
	input  wire pkt_t pkt_in,
	output logic      vld_q,
	output pkt_t      pkt_q
);

	logic [31:0] per_sec_q;
	logic [29:0] per_nsec_q;
	logic [32:0] dl_sec_q;
	logic [29:0] dl_nsec_q;

	logic        active, hit, ivl_nz;
	logic [31:0] src_sec;
	logic [29:0] src_nsec;
	logic [30:0] sum_ns;
	logic [32:0] sum_s;
	logic [32:0] new_sec;
	logic [29:0] new_nsec;
	logic        wr_per, wr_dl, clr;
	pkt_t        pkt_d;

	assign active = (per_sec_q != '0) || (per_nsec_q != '0);
	assign hit    = (IDX < (2 ** SLOT_W)) && (pkt_in.slot == SLOT_W'(IDX));
	assign ivl_nz = (pkt_in.ivl_sec != '0) || (pkt_in.ivl_nsec != '0);

	// Arm takes the new interval, rearm the stored one.
	assign src_sec  = (pkt_in.mode == MODE_ARM) ? pkt_in.ivl_sec : per_sec_q;
	assign src_nsec = (pkt_in.mode == MODE_ARM) ? pkt_in.ivl_nsec : per_nsec_q;
	assign sum_ns   = {1'b0, src_nsec} + {1'b0, pkt_in.now_nsec};
	assign sum_s    = {1'b0, src_sec} + {1'b0, pkt_in.now_sec};

	always_comb begin
		if (sum_ns >= NS_PER_SEC) begin
			new_nsec = 30'(sum_ns - NS_PER_SEC);
			new_sec  = sum_s + 33'd1;
		end else begin
			new_nsec = sum_ns[29:0];
			new_sec  = sum_s;
		end
	end

	always_comb begin
		pkt_d  = pkt_in;
		wr_per = 1'b0;
		wr_dl  = 1'b0;
		clr    = 1'b0;
		case (pkt_in.mode)
			MODE_ARM: begin
				if (!pkt_in.found && ivl_nz && !active) begin
					wr_per      = 1'b1;
					wr_dl       = 1'b1;
					pkt_d.found = 1'b1;
					pkt_d.rslot = SLOT_W'(IDX);
				end
			end
			MODE_REARM: begin
				if (hit && active) begin
					wr_dl       = 1'b1;
					pkt_d.found = 1'b1;
					pkt_d.rslot = SLOT_W'(IDX);
				end
			end
			MODE_CANCEL: begin
				if (hit) begin
					clr = 1'b1;
					if (active) begin
						pkt_d.found = 1'b1;
						pkt_d.rslot = SLOT_W'(IDX);
					end
				end
			end
			MODE_QUERY: begin
				// Nanoseconds stay below one second, so the joined word orders correctly.
				if (active && (!pkt_in.found ||
						{dl_sec_q, dl_nsec_q} < {pkt_in.best_sec, pkt_in.best_nsec})) begin
					pkt_d.found     = 1'b1;
					pkt_d.rslot     = SLOT_W'(IDX);
					pkt_d.best_sec  = dl_sec_q;
					pkt_d.best_nsec = dl_nsec_q;
				end
			end
			MODE_POLL: begin
				if (!pkt_in.found && active &&
						{dl_sec_q, dl_nsec_q} <= {1'b0, pkt_in.now_sec, pkt_in.now_nsec}) begin
					pkt_d.found = 1'b1;
					pkt_d.rslot = SLOT_W'(IDX);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_sec_q  <= '0;
			per_nsec_q <= '0;
			vld_q      <= 1'b0;
		end else begin
			vld_q <= vld_in;
			if (vld_in && clr) begin
				per_sec_q  <= '0;
				per_nsec_q <= '0;
			end else if (vld_in && wr_per) begin
				per_sec_q  <= pkt_in.ivl_sec;
				per_nsec_q <= pkt_in.ivl_nsec;
			end
		end
	end

	always_ff @(posedge clk) begin
		pkt_q <= pkt_d;
		if (vld_in && wr_dl) begin
			dl_sec_q  <= new_sec;
			dl_nsec_q <= new_nsec;
		end
	end

endmodule
`default_nettype wire
